@@ rtl/i2cm_pkg.sv @@
package i2cm_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int BYTE_BITS = 8;
    localparam int DELAY_WIDTH = 16;
    localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = 16'd500;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic                 cmd_valid;
        logic [1:0]           opcode;
        logic [BYTE_BITS-1:0] write_byte;
        logic                 send_ack;
        logic                 sda_in;
    } cmd_t;

    typedef struct packed {
        logic                 scl_pull_low;
        logic                 sda_pull_low;
        logic                 busy_res;
        logic                 done_res;
        logic [BYTE_BITS-1:0] read_byte;
        logic                 ack_seen;
        logic                 rejected;
    } res_t;

endpackage

@@ rtl/i2cm_seq.sv @@
module i2cm_seq
    import i2cm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  cmd_t                   cmd,
    input  logic [DELAY_WIDTH-1:0] delay_ticks,
    output res_t                   res
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_A    = 4'd1,
        PH_ST_B    = 4'd2,
        PH_SP_A    = 4'd3,
        PH_SP_B    = 4'd4,
        PH_SP_C    = 4'd5,
        PH_WR_HIGH = 4'd6,
        PH_WR_LOW  = 4'd7,
        PH_WA_HIGH = 4'd8,
        PH_WA_SAMP = 4'd9,
        PH_RD_HIGH = 4'd10,
        PH_RD_SAMP = 4'd11,
        PH_RA_HIGH = 4'd12,
        PH_RA_END  = 4'd13
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             bit_index_reg, bit_index_next;
    logic [BYTE_BITS-1:0]   shift_reg, shift_next;
    logic [COUNT_WIDTH-1:0] wait_reg, wait_next;
    logic                   scl_drive_reg, scl_drive_next;
    logic                   sda_drive_reg, sda_drive_next;
    logic                   ack_flag_reg, ack_flag_next;
    logic                   ack_choice_reg, ack_choice_next;
    logic [BYTE_BITS-1:0]   received_reg, received_next;
    logic                   done_next;
    logic                   rej_next;

    logic [31:0]            delay_ext;
    logic [COUNT_WIDTH-1:0] delay_masked;
    logic [COUNT_WIDTH-1:0] load_value;
    logic [COUNT_WIDTH-1:0] wait_dec;
    logic [3:0]             bit_index_inc;
    logic [BYTE_BITS-1:0]   shift_left;

    // A delay of zero after masking to the counter width behaves as one tick.
    assign delay_ext    = {{(32-DELAY_WIDTH){1'b0}}, delay_ticks};
    assign delay_masked = delay_ext[COUNT_WIDTH-1:0];
    assign load_value   = (delay_masked == '0) ? COUNT_WIDTH'(1) : delay_masked;
    assign wait_dec     = wait_reg - COUNT_WIDTH'(1);
    assign bit_index_inc = bit_index_reg + 4'd1;
    assign shift_left   = {shift_reg[BYTE_BITS-2:0], 1'b0};

    always_comb
    begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        wait_next       = wait_reg;
        scl_drive_next  = scl_drive_reg;
        sda_drive_next  = sda_drive_reg;
        ack_flag_next   = ack_flag_reg;
        ack_choice_next = ack_choice_reg;
        received_next   = received_reg;
        done_next       = 1'b0;
        rej_next        = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (cmd.cmd_valid)
            begin
                bit_index_next = 4'd0;
                wait_next      = load_value;
                case (op_t'(cmd.opcode))
                    OP_START:
                    begin
                        sda_drive_next = 1'b0;
                        scl_drive_next = 1'b0;
                        phase_next     = PH_ST_A;
                    end
                    OP_STOP:
                    begin
                        sda_drive_next = 1'b1;
                        phase_next     = PH_SP_A;
                    end
                    OP_WRITE:
                    begin
                        shift_next     = cmd.write_byte;
                        sda_drive_next = ~cmd.write_byte[BYTE_BITS-1];
                        phase_next     = PH_WR_HIGH;
                    end
                    default:
                    begin
                        ack_choice_next = cmd.send_ack;
                        shift_next      = '0;
                        sda_drive_next  = 1'b0;
                        phase_next      = PH_RD_HIGH;
                    end
                endcase
            end
        end
        else
        begin
            rej_next  = cmd.cmd_valid;
            wait_next = wait_dec;
            if (wait_dec == '0)
            begin
                case (phase_reg)
                    PH_ST_A:
                    begin
                        sda_drive_next = 1'b1;
                        wait_next      = load_value;
                        phase_next     = PH_ST_B;
                    end
                    PH_ST_B:
                    begin
                        scl_drive_next = 1'b1;
                        phase_next     = PH_IDLE;
                        done_next      = 1'b1;
                    end
                    PH_SP_A:
                    begin
                        scl_drive_next = 1'b0;
                        wait_next      = load_value;
                        phase_next     = PH_SP_B;
                    end
                    PH_SP_B:
                    begin
                        sda_drive_next = 1'b0;
                        wait_next      = load_value;
                        phase_next     = PH_SP_C;
                    end
                    PH_SP_C:
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    PH_WR_HIGH:
                    begin
                        scl_drive_next = 1'b0;
                        wait_next      = load_value;
                        phase_next     = PH_WR_LOW;
                    end
                    PH_WR_LOW:
                    begin
                        scl_drive_next = 1'b1;
                        shift_next     = shift_left;
                        bit_index_next = bit_index_inc;
                        wait_next      = load_value;
                        if (bit_index_inc < 4'(BYTE_BITS))
                        begin
                            sda_drive_next = ~shift_left[BYTE_BITS-1];
                            phase_next     = PH_WR_HIGH;
                        end
                        else
                        begin
                            // Release SDA so the slave can drive its acknowledge.
                            sda_drive_next = 1'b0;
                            phase_next     = PH_WA_HIGH;
                        end
                    end
                    PH_WA_HIGH:
                    begin
                        scl_drive_next = 1'b0;
                        wait_next      = load_value;
                        phase_next     = PH_WA_SAMP;
                    end
                    PH_WA_SAMP:
                    begin
                        ack_flag_next  = ~cmd.sda_in;
                        scl_drive_next = 1'b1;
                        phase_next     = PH_IDLE;
                        done_next      = 1'b1;
                    end
                    PH_RD_HIGH:
                    begin
                        scl_drive_next = 1'b0;
                        wait_next      = load_value;
                        phase_next     = PH_RD_SAMP;
                    end
                    PH_RD_SAMP:
                    begin
                        shift_next     = {shift_reg[BYTE_BITS-2:0], cmd.sda_in};
                        scl_drive_next = 1'b1;
                        bit_index_next = bit_index_inc;
                        wait_next      = load_value;
                        if (bit_index_inc < 4'(BYTE_BITS))
                        begin
                            phase_next = PH_RD_HIGH;
                        end
                        else
                        begin
                            sda_drive_next = ack_choice_reg;
                            phase_next     = PH_RA_HIGH;
                        end
                    end
                    PH_RA_HIGH:
                    begin
                        scl_drive_next = 1'b0;
                        wait_next      = load_value;
                        phase_next     = PH_RA_END;
                    end
                    PH_RA_END:
                    begin
                        scl_drive_next = 1'b1;
                        sda_drive_next = 1'b0;
                        received_next  = shift_reg;
                        phase_next     = PH_IDLE;
                        done_next      = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            wait_reg       <= '0;
            scl_drive_reg  <= 1'b0;
            sda_drive_reg  <= 1'b0;
            ack_flag_reg   <= 1'b0;
            ack_choice_reg <= 1'b0;
            received_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            wait_reg       <= wait_next;
            scl_drive_reg  <= scl_drive_next;
            sda_drive_reg  <= sda_drive_next;
            ack_flag_reg   <= ack_flag_next;
            ack_choice_reg <= ack_choice_next;
            received_reg   <= received_next;
        end
    end

    always_comb
    begin
        res.scl_pull_low = scl_drive_next;
        res.sda_pull_low = sda_drive_next;
        res.busy_res     = (phase_next != PH_IDLE);
        res.done_res     = done_next;
        res.read_byte    = received_next;
        res.ack_seen     = ack_flag_next;
        res.rejected     = rej_next;
    end

endmodule

@@ rtl/i2cm_skid.sv @@
module i2cm_skid
    import i2cm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  res_t in_res,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_res
);

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic accept_in;
    logic take_out;

    assign in_stall  = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;
    assign accept_in = in_valid & ~skid_valid_reg;
    assign take_out  = main_valid_reg & ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take_out)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= accept_in;
            end
        end
        else if (accept_in)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (accept_in)
            begin
                main_reg <= in_res;
            end
        end
        else if (accept_in)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= in_res;
            end
            else
            begin
                main_reg <= in_res;
            end
        end
    end

endmodule

@@ rtl/i2c_master_byte_engine.sv @@
// Channel   Direction  Handshake            Payload
// request   in         in_valid/in_stall    cmd_valid opcode write_byte send_ack sda_in
// result    out        out_valid/out_stall  scl_pull_low sda_pull_low busy_res done_res
//                                           read_byte ack_seen rejected
// config    in         cfg_wr_en            cfg_wr_data (delay_ticks)
//
// Each request is one bus tick and yields one result; one request per cycle is taken unless stalled.
// The sequencer step is a single pass of logic into the output register.
// A two-entry output buffer lets a request be taken while the previous result is held.
// The input stalls only while both buffer entries hold results the consumer has not taken.
// Reset is asynchronous and active low; it returns the bus drives to released and the delay to 500.

module i2c_master_byte_engine
    import i2cm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [DELAY_WIDTH-1:0] cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd_valid,
    input  logic [1:0]             opcode,
    input  logic [BYTE_BITS-1:0]   write_byte,
    input  logic                   send_ack,
    input  logic                   sda_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   scl_pull_low,
    output logic                   sda_pull_low,
    output logic                   busy_res,
    output logic                   done_res,
    output logic [BYTE_BITS-1:0]   read_byte,
    output logic                   ack_seen,
    output logic                   rejected
);

    logic [DELAY_WIDTH-1:0] delay_reg;
    logic                   accept;
    cmd_t                   cmd;
    res_t                   seq_res;
    res_t                   out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
        end
        else if (cfg_wr_en)
        begin
            delay_reg <= cfg_wr_data;
        end
    end

    assign accept = in_valid & ~in_stall;

    assign cmd.cmd_valid  = cmd_valid;
    assign cmd.opcode     = opcode;
    assign cmd.write_byte = write_byte;
    assign cmd.send_ack   = send_ack;
    assign cmd.sda_in     = sda_in;

    i2cm_seq #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd),
        .delay_ticks (delay_reg),
        .res         (seq_res)
    );

    i2cm_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_res    (seq_res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign scl_pull_low = out_res.scl_pull_low;
    assign sda_pull_low = out_res.sda_pull_low;
    assign busy_res     = out_res.busy_res;
    assign done_res     = out_res.done_res;
    assign read_byte    = out_res.read_byte;
    assign ack_seen     = out_res.ack_seen;
    assign rejected     = out_res.rejected;

`ifndef ASSERT_OFF
    // The buffer only pushes back when it already holds a result for the consumer.
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // A completing command always leaves the sequencer idle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res)
        else $error("done reported while still busy");

    // A command is only dropped while a sequence runs, so the tick stays busy or completes.
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (busy_res || done_res))
        else $error("rejection on an idle tick");
`endif

endmodule

@@ bench/i2c_master_byte_engine_test.sv @@
`timescale 1ns / 1ps

module i2c_master_byte_engine_test;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_TICKS = 16;

    typedef enum logic [3:0] {
        BUS_IDLE,
        BUS_START_A,
        BUS_START_B,
        BUS_STOP_A,
        BUS_STOP_B,
        BUS_STOP_C,
        BUS_WRITE_HIGH,
        BUS_WRITE_LOW,
        BUS_WACK_HIGH,
        BUS_WACK_SAMPLE,
        BUS_READ_HIGH,
        BUS_READ_SAMPLE,
        BUS_RACK_HIGH,
        BUS_RACK_END
    } bus_phase_t;

    typedef enum int {
        SDA_LOW,
        SDA_HIGH,
        SDA_RANDOM
    } sda_pattern_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [DELAY_WIDTH-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd_valid = 1'b0;
    logic [1:0] opcode = '0;
    logic [BYTE_BITS-1:0] write_byte = '0;
    logic send_ack = 1'b0;
    logic sda_in = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic scl_pull_low;
    logic sda_pull_low;
    logic busy_res;
    logic done_res;
    logic [BYTE_BITS-1:0] read_byte;
    logic ack_seen;
    logic rejected;

    cmd_t tick_queue[$];
    res_t predicted_bus[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int cycles = 0;
    int unsigned queued_ticks = 0;
    logic req_taken = 1'b0;
    logic hold_request = 1'b0;
    logic hold_seen = 1'b0;
    int hold_left = 0;

    // Stimulus-side view of the delay, used to time well-formed command sequences.
    logic [DELAY_WIDTH-1:0] gen_delay = DELAY_RESET;
    logic left_running = 1'b0;

    // Predicted sequencer state.
    bus_phase_t seq_phase = BUS_IDLE;
    logic [3:0] seq_bits = '0;
    logic [7:0] seq_shift = '0;
    logic [15:0] seq_wait = '0;
    logic seq_scl = 1'b0;
    logic seq_sda = 1'b0;
    logic seq_ack_seen = 1'b0;
    logic seq_ack_choice = 1'b0;
    logic [7:0] seq_rx = '0;
    logic [DELAY_WIDTH-1:0] seq_delay = DELAY_RESET;

    i2c_master_byte_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd_valid    (cmd_valid),
        .opcode       (opcode),
        .write_byte   (write_byte),
        .send_ack     (send_ack),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_pull_low (scl_pull_low),
        .sda_pull_low (sda_pull_low),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .read_byte    (read_byte),
        .ack_seen     (ack_seen),
        .rejected     (rejected)
    );

    always #4 clk = ~clk;

    function automatic int unsigned eff_delay(logic [DELAY_WIDTH-1:0] d);
        return (d == 0) ? 1 : int'(d);
    endfunction

    function automatic void arm_delay(bus_phase_t nxt);
        seq_wait = (seq_delay == 0) ? 16'd1 : seq_delay;
        seq_phase = nxt;
    endfunction

    // One bus tick of the sequencer: returns the outputs shown for that tick.
    function automatic res_t bus_tick(cmd_t t);
        res_t r;
        logic done;
        logic rej;
        done = 1'b0;
        rej = 1'b0;
        if (seq_phase == BUS_IDLE)
        begin
            if (t.cmd_valid)
            begin
                seq_bits = '0;
                case (op_t'(t.opcode))
                    OP_START:
                    begin
                        seq_sda = 1'b0;
                        seq_scl = 1'b0;
                        arm_delay(BUS_START_A);
                    end
                    OP_STOP:
                    begin
                        seq_sda = 1'b1;
                        arm_delay(BUS_STOP_A);
                    end
                    OP_WRITE:
                    begin
                        seq_shift = t.write_byte;
                        seq_sda = ~seq_shift[7];
                        arm_delay(BUS_WRITE_HIGH);
                    end
                    default:
                    begin
                        seq_ack_choice = t.send_ack;
                        seq_shift = '0;
                        seq_sda = 1'b0;
                        arm_delay(BUS_READ_HIGH);
                    end
                endcase
            end
        end
        else
        begin
            rej = t.cmd_valid;
            seq_wait = seq_wait - 16'd1;
            if (seq_wait == 0)
            begin
                case (seq_phase)
                    BUS_START_A:
                    begin
                        seq_sda = 1'b1;
                        arm_delay(BUS_START_B);
                    end
                    BUS_START_B:
                    begin
                        seq_scl = 1'b1;
                        seq_phase = BUS_IDLE;
                        done = 1'b1;
                    end
                    BUS_STOP_A:
                    begin
                        seq_scl = 1'b0;
                        arm_delay(BUS_STOP_B);
                    end
                    BUS_STOP_B:
                    begin
                        seq_sda = 1'b0;
                        arm_delay(BUS_STOP_C);
                    end
                    BUS_STOP_C:
                    begin
                        seq_phase = BUS_IDLE;
                        done = 1'b1;
                    end
                    BUS_WRITE_HIGH:
                    begin
                        seq_scl = 1'b0;
                        arm_delay(BUS_WRITE_LOW);
                    end
                    BUS_WRITE_LOW:
                    begin
                        seq_scl = 1'b1;
                        seq_shift = seq_shift << 1;
                        seq_bits = seq_bits + 4'd1;
                        if (seq_bits < BYTE_BITS)
                        begin
                            seq_sda = ~seq_shift[7];
                            arm_delay(BUS_WRITE_HIGH);
                        end
                        else
                        begin
                            seq_sda = 1'b0;
                            arm_delay(BUS_WACK_HIGH);
                        end
                    end
                    BUS_WACK_HIGH:
                    begin
                        seq_scl = 1'b0;
                        arm_delay(BUS_WACK_SAMPLE);
                    end
                    BUS_WACK_SAMPLE:
                    begin
                        seq_ack_seen = ~t.sda_in;
                        seq_scl = 1'b1;
                        seq_phase = BUS_IDLE;
                        done = 1'b1;
                    end
                    BUS_READ_HIGH:
                    begin
                        seq_scl = 1'b0;
                        arm_delay(BUS_READ_SAMPLE);
                    end
                    BUS_READ_SAMPLE:
                    begin
                        seq_shift = {seq_shift[6:0], t.sda_in};
                        seq_scl = 1'b1;
                        seq_bits = seq_bits + 4'd1;
                        if (seq_bits < BYTE_BITS)
                        begin
                            arm_delay(BUS_READ_HIGH);
                        end
                        else
                        begin
                            seq_sda = seq_ack_choice;
                            arm_delay(BUS_RACK_HIGH);
                        end
                    end
                    BUS_RACK_HIGH:
                    begin
                        seq_scl = 1'b0;
                        arm_delay(BUS_RACK_END);
                    end
                    BUS_RACK_END:
                    begin
                        seq_scl = 1'b1;
                        seq_sda = 1'b0;
                        seq_rx = seq_shift;
                        seq_phase = BUS_IDLE;
                        done = 1'b1;
                    end
                    default:
                    begin
                        seq_phase = BUS_IDLE;
                    end
                endcase
            end
        end
        r.scl_pull_low = seq_scl;
        r.sda_pull_low = seq_sda;
        r.busy_res = (seq_phase != BUS_IDLE);
        r.done_res = done;
        r.read_byte = seq_rx;
        r.ack_seen = seq_ack_seen;
        r.rejected = rej;
        return r;
    endfunction

    function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        end
    endfunction

    function automatic int unsigned busy_span(op_t op);
        int unsigned phases;
        case (op)
            OP_START: phases = 2;
            OP_STOP:  phases = 3;
            default:  phases = 18;
        endcase
        return phases * eff_delay(gen_delay);
    endfunction

    function automatic logic pick_sda(sda_pattern_t pat);
        case (pat)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic cmd_t random_tick(int cmd_pct, sda_pattern_t pat);
        cmd_t t;
        t.cmd_valid = ($urandom_range(0, 99) < cmd_pct);
        t.opcode = 2'($urandom_range(0, 3));
        t.write_byte = 8'($urandom_range(0, 255));
        t.send_ack = 1'($urandom_range(0, 1));
        t.sda_in = pick_sda(pat);
        return t;
    endfunction

    task automatic queue_tick(cmd_t t);
        tick_queue.push_back(t);
        queued_ticks++;
    endtask

    task automatic queue_idle(int unsigned n);
        repeat (n) queue_tick(random_tick(0, SDA_RANDOM));
    endtask

    // A command tick followed by gap filler ticks. Stray commands appear only while
    // the engine is busy (up to and including its done tick), so they are all dropped.
    task automatic queue_command(op_t op, logic [7:0] data, logic ack, sda_pattern_t pat,
                                 int unsigned gap, int noise_pct);
        cmd_t t;
        int unsigned span;
        span = busy_span(op);
        t = random_tick(100, pat);
        t.opcode = op;
        t.write_byte = data;
        t.send_ack = ack;
        queue_tick(t);
        for (int unsigned i = 0; i < gap; i++)
            queue_tick(random_tick((i < span) ? noise_pct : 0, pat));
    endtask

    // Checked at the rising edge, where the driven inputs are settled.
    task automatic drain_bus();
        do @(posedge clk);
        while (tick_queue.size() != 0 || in_valid || predicted_bus.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_delay(logic [DELAY_WIDTH-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        seq_delay = value;
        gen_delay = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(logic [DELAY_WIDTH-1:0] d, int send_pct, int stall_pct,
                             logic with_hold);
        int unsigned tail;
        int unsigned start_count;
        op_t op;
        sda_pattern_t pat;
        tail = 19 * ((eff_delay(gen_delay) > eff_delay(d)) ? eff_delay(gen_delay)
                                                            : eff_delay(d)) + 2;
        set_delay(d);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        if (with_hold)
            hold_request = ~hold_request;
        // The previous phase may have left a command running across the delay change.
        if (left_running)
            queue_idle(tail);
        start_count = queued_ticks;
        while (queued_ticks - start_count < PHASE_TICKS)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                op = op_t'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0:       pat = SDA_LOW;
                    1:       pat = SDA_HIGH;
                    default: pat = SDA_RANDOM;
                endcase
                queue_command(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pat,
                              busy_span(op) + $urandom_range(0, 2), 8);
            end
            else
            begin
                repeat ($urandom_range(4, 12)) queue_tick(random_tick(30, SDA_RANDOM));
                queue_idle(19 * eff_delay(gen_delay) + 2);
            end
        end
        op = op_t'($urandom_range(0, 3));
        queue_command(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_RANDOM,
                      $urandom_range(0, 6), 8);
        left_running = 1'b1;
        drain_bus();
    endtask

    // Request driver: a request stays on the port until it is taken.
    always @(negedge clk)
    begin : feed_requests
        cmd_t next_tick;
        if (rst_n && (!in_valid || req_taken))
        begin
            if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_tick = tick_queue.pop_front();
                in_valid <= 1'b1;
                cmd_valid <= next_tick.cmd_valid;
                opcode <= next_tick.opcode;
                write_byte <= next_tick.write_byte;
                send_ack <= next_tick.send_ack;
                sda_in <= next_tick.sda_in;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watch_bus
        res_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_bus.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with no request outstanding");
                end
                else
                begin
                    want = predicted_bus.pop_front();
                    compare_field("scl_pull_low", want.scl_pull_low, scl_pull_low);
                    compare_field("sda_pull_low", want.sda_pull_low, sda_pull_low);
                    compare_field("busy_res", want.busy_res, busy_res);
                    compare_field("done_res", want.done_res, done_res);
                    compare_field("read_byte", want.read_byte, read_byte);
                    compare_field("ack_seen", want.ack_seen, ack_seen);
                    compare_field("rejected", want.rejected, rejected);
                end
            end
            req_taken = in_valid && !in_stall;
            if (req_taken)
                predicted_bus.push_back(bus_tick(cmd_t'({cmd_valid, opcode, write_byte,
                                                          send_ack, sda_in})));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        int sender_idle[4] = '{0, 74, 0, 26};
        int recv_idle[4] = '{0, 0, 74, 26};
        logic [DELAY_WIDTH-1:0] phase_delay[8] = '{1, 2, 1, 0, 3, 1, 2, 1};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // The first interval of a start runs on the delay out of reset; a new delay
        // written meanwhile applies from the second interval on.
        queue_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 4, 0);
        drain_bus();
        set_delay(16'd1);
        queue_idle(eff_delay(DELAY_RESET) + 2);
        drain_bus();

        queue_command(OP_WRITE, 8'h00, 1'b0, SDA_LOW, busy_span(OP_WRITE), 0);
        queue_command(OP_WRITE, 8'hFF, 1'b1, SDA_HIGH, busy_span(OP_WRITE), 0);
        queue_command(OP_WRITE, 8'hA5, 1'b0, SDA_RANDOM, busy_span(OP_WRITE) + 2, 0);
        queue_command(OP_READ, 8'h00, 1'b1, SDA_HIGH, busy_span(OP_READ), 0);
        queue_command(OP_READ, 8'hFF, 1'b0, SDA_LOW, busy_span(OP_READ), 0);
        queue_command(OP_READ, 8'h5A, 1'b1, SDA_RANDOM, busy_span(OP_READ) + 1, 0);
        // Commands on every busy tick, the completing tick included, must be dropped.
        queue_command(OP_STOP, 8'h81, 1'b1, SDA_RANDOM, busy_span(OP_STOP), 100);
        queue_command(OP_START, 8'h7E, 1'b0, SDA_RANDOM, busy_span(OP_START), 100);
        queue_command(OP_WRITE, 8'h96, 1'b1, SDA_RANDOM, busy_span(OP_WRITE), 100);
        queue_idle(2);
        drain_bus();

        // A zero delay behaves as one tick.
        set_delay(16'd0);
        queue_command(OP_WRITE, 8'h3C, 1'b0, SDA_RANDOM, busy_span(OP_WRITE), 0);
        queue_command(OP_READ, 8'hC3, 1'b0, SDA_RANDOM, busy_span(OP_READ), 0);
        queue_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, busy_span(OP_STOP) + 1, 0);
        drain_bus();

        set_delay(16'd2);
        queue_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, busy_span(OP_START) + 1, 0);
        drain_bus();

        for (int p = 0; p < 8; p++)
            run_phase(phase_delay[p], sender_idle[p % 4], recv_idle[p % 4], (p % 4) == 0);

        drain_bus();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && predicted_bus.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
